FILE: rtl/core/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants for the bounded sequence store
// Holds the list geometry, operation codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned Depth     = 256;
  localparam int unsigned ItemWidth = 32;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = AddrW + 1;

  typedef enum logic [2:0] {
    OpInsert = 3'd0,
    OpSorted = 3'd1,
    OpErase  = 3'd2,
    OpRemove = 3'd3,
    OpGet    = 3'd4,
    OpSet    = 3'd5,
    OpFind   = 3'd6,
    OpNone   = 3'd7
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             wr_sel_held;  // 1: write the word read last, 0: the input value
  } bss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             rd_eq;   // registered read word equals the operand
    logic             rd_lt;   // operand greater than the registered read word
  } bss_sts_t;

endpackage

FILE: rtl/core/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/bss_datapath.sv
// ----------------------------------------------------------------------------
// bss_datapath: item storage and compare for the bounded sequence store
// Holds the item RAM, the operand register and the equality/order compare.
// ----------------------------------------------------------------------------
module bss_datapath
  import bss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [ItemWidth-1:0] value_i,
  input  bss_cmd_t             cmd_i,
  output bss_sts_t             sts_o,
  output logic [ItemWidth-1:0] rd_data_o
);

  logic [ItemWidth-1:0] operand_q;
  logic [ItemWidth-1:0] rdata;
  logic [ItemWidth-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      operand_q <= value_i;
    end
  end

  assign wdata = cmd_i.wr_sel_held ? rdata : operand_q;

  bss_ram #(
    .Width(ItemWidth),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  assign sts_o.rd_eq = (rdata == operand_q);
  assign sts_o.rd_lt = (operand_q > rdata);
  assign rd_data_o   = rdata;

endmodule

FILE: rtl/core/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl: operation sequencer for the bounded sequence store
// Walks the RAM one word a cycle for shifts, searches and compaction.
// ----------------------------------------------------------------------------
module bss_ctrl
  import bss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CntW-1:0]      limit_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [8:0]           pos_i,
  output logic                 load_o,
  output bss_cmd_t             cmd_o,
  input  bss_sts_t             sts_i,
  input  logic [ItemWidth-1:0] rd_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ok_o,
  output logic [7:0]           rpos_o,
  output logic [8:0]           removed_o,
  output logic [31:0]          rdval_o,
  output logic [8:0]           count_o
);

  typedef enum logic [2:0] {
    StIdle, StSearch, StShiftUp, StShiftDn, StCompact, StGetWait, StDone
  } state_e;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;     // read index of the walk
  logic [CntW-1:0] wr_q, wr_d;       // write index for compaction
  logic            pend_q, pend_d;   // a read issued last cycle is valid now
  logic [CntW-1:0] pidx_q, pidx_d;   // index of that read
  logic [CntW-1:0] tgt_q, tgt_d;     // insert position
  logic            out_valid_q, out_valid_d;
  logic            ok_q, ok_d;
  logic [7:0]      rpos_q, rpos_d;
  logic [8:0]      removed_q, removed_d;
  logic [31:0]     rdval_q, rdval_d;
  logic [CntW-1:0] limit_eff;
  logic            room;
  logic [CntW-1:0] pos_ext;
  logic            pos_in;

  assign limit_eff = (limit_i < CntW'(Depth)) ? limit_i : CntW'(Depth);
  assign room      = count_q < limit_eff;
  assign pos_ext   = CntW'(pos_i);
  assign pos_in    = pos_ext < count_q;
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign load_o     = in_valid_i && in_ready_o;

  // RAM commands are decoded from the walk state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StSearch: begin
        cmd_o.rd_en   = idx_q < count_q;
        cmd_o.rd_addr = idx_q[AddrW-1:0];
      end
      StShiftUp: begin
        // read idx-1, write it to idx when it arrives
        cmd_o.rd_en       = idx_q > tgt_q;
        cmd_o.rd_addr     = AddrW'(idx_q - 1'b1);
        cmd_o.wr_en       = pend_q;
        cmd_o.wr_addr     = pidx_q[AddrW-1:0];
        cmd_o.wr_sel_held = 1'b1;
        if (!pend_q && idx_q == tgt_q) begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.wr_addr     = tgt_q[AddrW-1:0];
          cmd_o.wr_sel_held = 1'b0;
        end
      end
      StShiftDn: begin
        cmd_o.rd_en       = idx_q < count_q;
        cmd_o.rd_addr     = idx_q[AddrW-1:0];
        cmd_o.wr_en       = pend_q;
        cmd_o.wr_addr     = AddrW'(pidx_q - 1'b1);
        cmd_o.wr_sel_held = 1'b1;
      end
      StCompact: begin
        cmd_o.rd_en       = idx_q < count_q;
        cmd_o.rd_addr     = idx_q[AddrW-1:0];
        cmd_o.wr_en       = pend_q && !sts_i.rd_eq;
        cmd_o.wr_addr     = wr_q[AddrW-1:0];
        cmd_o.wr_sel_held = 1'b1;
      end
      StIdle: begin
        if (load_o && op_e'(mode_i) == OpGet && pos_in) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = pos_ext[AddrW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    pend_d      = cmd_o.rd_en;
    pidx_d      = idx_q;
    tgt_d       = tgt_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    rpos_d      = rpos_q;
    removed_d   = removed_q;
    rdval_d     = rdval_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (load_o) begin
          op_d      = op_e'(mode_i);
          ok_d      = 1'b0;
          rpos_d    = '0;
          removed_d = '0;
          rdval_d   = '0;
          idx_d     = '0;
          wr_d      = '0;
          unique case (op_e'(mode_i))
            OpInsert: begin
              if (room && pos_ext <= count_q) begin
                tgt_d   = pos_ext;
                idx_d   = count_q;
                ok_d    = 1'b1;
                rpos_d  = pos_ext[7:0];
                state_d = StShiftUp;
              end else begin
                state_d = StDone;
              end
            end
            OpSorted: state_d = room ? StSearch : StDone;
            OpErase: begin
              if (pos_in) begin
                idx_d   = pos_ext + 1'b1;
                ok_d    = 1'b1;
                state_d = StShiftDn;
              end else begin
                state_d = StDone;
              end
            end
            OpRemove: begin
              ok_d    = 1'b1;
              state_d = StCompact;
            end
            OpGet: begin
              if (pos_in) begin
                ok_d    = 1'b1;
                state_d = StGetWait;
              end else begin
                state_d = StDone;
              end
            end
            OpSet: begin
              // written from the operand register next cycle
              if (pos_in) begin
                ok_d    = 1'b1;
                tgt_d   = pos_ext;
                idx_d   = pos_ext;
                state_d = StShiftUp;
              end else begin
                state_d = StDone;
              end
            end
            OpFind: state_d = StSearch;
            default: state_d = StDone;
          endcase
        end
      end
      StSearch: begin
        if (cmd_o.rd_en) begin
          idx_d = idx_q + 1'b1;
        end
        // stop on the word that arrived this cycle
        if (pend_q && ((op_q == OpFind) ? sts_i.rd_eq : !sts_i.rd_lt)) begin
          ok_d   = 1'b1;
          rpos_d = pidx_q[7:0];
          if (op_q == OpFind) begin
            state_d = StDone;
          end else begin
            // drop the read in flight before shifting
            tgt_d   = pidx_q;
            idx_d   = count_q;
            pend_d  = 1'b0;
            state_d = StShiftUp;
          end
        end else if (!cmd_o.rd_en && !pend_q) begin
          if (op_q == OpFind) begin
            state_d = StDone;
          end else begin
            ok_d    = 1'b1;
            rpos_d  = count_q[7:0];
            tgt_d   = count_q;
            idx_d   = count_q;
            state_d = StShiftUp;
          end
        end
      end
      StShiftUp: begin
        if (cmd_o.rd_en) begin
          idx_d = idx_q - 1'b1;
        end
        if (!pend_q && idx_q == tgt_q) begin
          if (op_q != OpSet) begin
            count_d = count_q + 1'b1;
          end
          state_d = StDone;
        end
      end
      StShiftDn: begin
        if (cmd_o.rd_en) begin
          idx_d = idx_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
          state_d = StDone;
        end
      end
      StCompact: begin
        if (cmd_o.rd_en) begin
          idx_d = idx_q + 1'b1;
        end
        if (cmd_o.wr_en) begin
          wr_d = wr_q + 1'b1;
        end
        if (!cmd_o.rd_en && !pend_q) begin
          removed_d = 9'(count_q - wr_q);
          count_d   = wr_q;
          state_d   = StDone;
        end
      end
      StGetWait: begin
        rdval_d = 32'(rd_data_i);
        state_d = StDone;
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpNone;
      count_q     <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      tgt_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      rpos_q      <= '0;
      removed_q   <= '0;
      rdval_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      tgt_q       <= tgt_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      rpos_q      <= rpos_d;
      removed_q   <= removed_d;
      rdval_q     <= rdval_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign rpos_o      = rpos_q;
  assign removed_o   = removed_q;
  assign rdval_o     = rdval_q;
  assign count_o     = 9'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("count beyond depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready while busy");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> out_valid_q) else $error("result lost");
  a_ok_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> rpos_q == '0) else $error("position without ok");

endmodule

FILE: rtl/core/bounded_sequence_store.sv
// ----------------------------------------------------------------------------
// bounded_sequence_store: bounded ordered list with sorted insert
// Insert, sorted insert, erase, remove all, get, set and find on a RAM list.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tdata: mode[2:0], position[11:3], item_value[43:12]
//  m_axis    out        tdata: ok, result_position, removed_count, read_value,
//                       item_count
//  cfg       in         capacity_limit, 9 bits
//
// One transaction at a time: shifts, searches and compaction walk the RAM one
// word a cycle, set by the single RAM read port. The next input is taken after
// the result is delivered. Reset empties the list and sets the limit to 256;
// stored words need no clearing.
module bounded_sequence_store
  import bss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // mode[2:0] position[11:3] item_value[43:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // ok[0] rpos[8:1] removed[17:9] read[49:18] cnt[58:50]
);

  logic [8:0]  limit_q;
  logic        load;
  bss_cmd_t    cmd;
  bss_sts_t    sts;
  logic [ItemWidth-1:0] rd_data;
  logic        ok;
  logic [7:0]  rpos;
  logic [8:0]  removed, cnt;
  logic [31:0] rdval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 9'd256;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (CntW'(limit_q)),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tdata[2:0]),
    .pos_i      (s_axis_tdata[11:3]),
    .load_o     (load),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .rd_data_i  (rd_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ok_o       (ok),
    .rpos_o     (rpos),
    .removed_o  (removed),
    .rdval_o    (rdval),
    .count_o    (cnt)
  );

  bss_datapath u_dp (
    .clk_i    (clk_i),
    .load_i   (load),
    .value_i  (ItemWidth'(s_axis_tdata[43:12])),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .rd_data_o(rd_data)
  );

  assign m_axis_tdata = {5'd0, cnt, rdval, removed, rpos, ok};

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded sequence store
// Drives list operations over the input stream, predicts each result from a
// local copy of the list and limit, and compares every output transaction.
// ----------------------------------------------------------------------------
module tb
  import bss_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  pos;
    logic [2:0]  op;
  } list_op_t;

  typedef struct packed {
    logic [8:0]  cnt;
    logic [31:0] rd;
    logic [8:0]  removed;
    logic [7:0]  rpos;
    logic        ok;
  } list_res_t;

  localparam int unsigned TimeoutCycles = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // mode[2:0] position[11:3] item_value[43:12]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // ok rpos removed read_value item_count

  bounded_sequence_store u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Model state
  logic [31:0] list_mem [Depth];
  int unsigned list_cnt = 0;
  int unsigned cap_limit;

  list_op_t    pending_ops[$];
  list_res_t   expected_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_cnt = 0;
  longint unsigned cycle_cnt = 0;

  function automatic list_res_t apply_op(list_op_t t);
    list_res_t   r;
    int unsigned lim;
    int unsigned i;
    int unsigned w;
    bit          room;
    r = '0;
    lim = (cap_limit < Depth) ? cap_limit : Depth;
    room = list_cnt < lim;
    case (op_e'(t.op))
      OpInsert, OpSorted: begin
        if (room && (op_e'(t.op) == OpSorted || t.pos <= list_cnt)) begin
          if (op_e'(t.op) == OpSorted) begin
            i = 0;
            while (i < list_cnt && t.value > list_mem[i]) i++;
          end else begin
            i = t.pos;
          end
          for (w = list_cnt; w > i; w--) list_mem[w] = list_mem[w-1];
          list_mem[i] = t.value;
          list_cnt++;
          r.ok = 1'b1;
          r.rpos = i[7:0];
        end
      end
      OpErase: begin
        if (t.pos < list_cnt) begin
          for (i = t.pos; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
          r.ok = 1'b1;
        end
      end
      OpRemove: begin
        w = 0;
        for (i = 0; i < list_cnt; i++)
          if (list_mem[i] != t.value) begin
            list_mem[w] = list_mem[i];
            w++;
          end
        r.removed = 9'(list_cnt - w);
        list_cnt = w;
        r.ok = 1'b1;
      end
      OpGet: begin
        if (t.pos < list_cnt) begin
          r.rd = list_mem[t.pos];
          r.ok = 1'b1;
        end
      end
      OpSet: begin
        if (t.pos < list_cnt) begin
          list_mem[t.pos] = t.value;
          r.ok = 1'b1;
        end
      end
      OpFind: begin
        for (i = 0; i < list_cnt; i++)
          if (list_mem[i] == t.value) begin
            r.ok = 1'b1;
            r.rpos = i[7:0];
            break;
          end
      end
      default: ;
    endcase
    r.cnt = 9'(list_cnt);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Driver: pop the next op when the bus is free or the current one was taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        list_op_t t;
        t = pending_ops.pop_front();
        expected_results.push_back(apply_op(t));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, t};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        list_res_t got;
        list_res_t exp_r;
        got = m_axis_tdata[58:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          error_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.ok !== exp_r.ok) begin
            $error("ok: expected %0d actual %0d", exp_r.ok, got.ok);
            error_cnt++;
          end
          if (got.rpos !== exp_r.rpos) begin
            $error("result_position: expected %0d actual %0d",
                   exp_r.rpos, got.rpos);
            error_cnt++;
          end
          if (got.removed !== exp_r.removed) begin
            $error("removed_count: expected %0d actual %0d",
                   exp_r.removed, got.removed);
            error_cnt++;
          end
          if (got.rd !== exp_r.rd) begin
            $error("read_value: expected %h actual %h", exp_r.rd, got.rd);
            error_cnt++;
          end
          if (got.cnt !== exp_r.cnt) begin
            $error("item_count: expected %0d actual %0d", exp_r.cnt, got.cnt);
            error_cnt++;
          end
        end
      end
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TimeoutCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 6) return 32'($urandom_range(15));
    if (k == 6) return 32'hFFFF_FFFF;
    if (k == 7) return 32'hFFFF_FFF0 + 32'($urandom_range(15));
    return $urandom;
  endfunction

  function automatic list_op_t make_op(op_e op, int unsigned pos, logic [31:0] value);
    list_op_t t;
    t.op = op;
    t.pos = 9'(pos);
    t.value = value;
    return t;
  endfunction

  // Rough list size for shaping positions; exact state is tracked by the driver
  function automatic int unsigned list_cnt_estimate();
    return (list_cnt > 8) ? list_cnt : 8;
  endfunction

  // Random ops, weighted toward valid positions and inserts to build up the list
  task automatic queue_random(int unsigned n, int unsigned fill_bias);
    int unsigned span;
    int unsigned k;
    op_e         op;
    for (int unsigned j = 0; j < n; j++) begin
      k = $urandom_range(99);
      if (k < fill_bias) op = ($urandom_range(1) != 0) ? OpInsert : OpSorted;
      else if (k < 97) op = op_e'($urandom_range(2, 6));
      else op = op_e'($urandom_range(7));
      span = (list_cnt_estimate() + 1);
      if ($urandom_range(9) == 0) k = $urandom_range(511);
      else k = $urandom_range(span);
      pending_ops.push_back(make_op(op, k, pick_value()));
    end
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 9'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_limit = v;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    cap_limit     = 256;
    send_idle_pct = 20;
    recv_idle_pct = 67;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every op, empty list, bounds, duplicates, extremes, bad mode
    pending_ops.push_back(make_op(OpGet, 0, 0));
    pending_ops.push_back(make_op(OpFind, 0, 0));
    pending_ops.push_back(make_op(OpErase, 0, 0));
    pending_ops.push_back(make_op(OpInsert, 1, 5));
    pending_ops.push_back(make_op(OpInsert, 0, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OpInsert, 0, 0));
    pending_ops.push_back(make_op(OpSorted, 0, 7));
    pending_ops.push_back(make_op(OpSorted, 0, 7));
    pending_ops.push_back(make_op(OpSorted, 511, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OpInsert, 5, 32'hA5A5_5A5A));
    pending_ops.push_back(make_op(OpGet, 5, 0));
    pending_ops.push_back(make_op(OpGet, 6, 0));
    pending_ops.push_back(make_op(OpSet, 2, 32'h5A5A_A5A5));
    pending_ops.push_back(make_op(OpSet, 511, 1));
    pending_ops.push_back(make_op(OpFind, 0, 7));
    pending_ops.push_back(make_op(OpFind, 0, 12345));
    pending_ops.push_back(make_op(OpRemove, 0, 7));
    pending_ops.push_back(make_op(OpRemove, 0, 999));
    pending_ops.push_back(make_op(OpErase, 0, 0));
    pending_ops.push_back(make_op(OpErase, 256, 0));
    pending_ops.push_back(make_op(OpNone, 0, 0));
    pending_ops.push_back(make_op(OpGet, 1, 0));
    drain();

    // Small limit: fill, overflow, then lower below count
    write_limit(4);
    queue_random(40, 60);
    drain();
    write_limit(1);
    queue_random(30, 50);
    drain();
    write_limit(0);
    queue_random(20, 50);
    drain();
    write_limit(511);
    queue_random(100, 45);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 20;
    write_limit(16);
    queue_random(100, 40);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(256);
    // Fill to the full depth once, then hit it
    for (int unsigned j = 0; j < 260; j++)
      pending_ops.push_back(make_op(OpSorted, 0, $urandom));
    drain();
    pending_ops.push_back(make_op(OpGet, 255, 0));
    pending_ops.push_back(make_op(OpErase, 0, 0));
    queue_random(76, 30);
    drain();

    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
